// ----- hdl/drfr_pkg.sv -----
// Shared types and constants for the dual-channel frame receiver.
package drfr_pkg;

    localparam int NUM_BUFFERS_DEF = 4;
    localparam int BUF_W           = 2;
    localparam int BYTE_W          = 8;

    localparam logic [BYTE_W-1:0] START_BYTE    = 8'h7E;
    localparam logic [BYTE_W-1:0] SUM_TARGET    = 8'hFF;
    localparam logic [BYTE_W-1:0] MAX_LEN_RESET = 8'd111;

    typedef enum logic [1:0] {
        CMD_BYTE    = 2'd0,
        CMD_RETURN  = 2'd1,
        CMD_RESUME  = 2'd2,
        CMD_SUSPEND = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        ERR_NONE      = 3'd0,
        ERR_FRAMING   = 3'd1,
        ERR_OVERRUN   = 3'd2,
        ERR_NO_BUFFER = 3'd3,
        ERR_CHECKSUM  = 3'd4,
        ERR_LEN_HIGH  = 3'd5,
        ERR_LEN_RANGE = 3'd6
    } t_err;

    typedef struct packed {
        t_cmd              cmd;
        logic              channel;
        logic [BYTE_W-1:0] rx_byte;
        logic              overrun_flag;
        logic              framing_flag;
        logic [BUF_W-1:0]  returned_buffer;
    } t_rx_req;

    typedef struct packed {
        logic              write_valid;
        logic [BUF_W-1:0]  write_buffer;
        logic [BYTE_W-1:0] write_offset;
        logic [BYTE_W-1:0] write_data;
        logic              frame_done;
        logic [BYTE_W-1:0] frame_length;
        logic              event_channel;
        t_err              error_code;
        logic              rts_hold_0;
        logic              rts_hold_1;
    } t_rx_res;

    // top -> channel
    typedef struct packed {
        logic              byte_en;
        logic [BYTE_W-1:0] rx_byte;
        logic              overrun;
        logic              framing;
        logic [BYTE_W-1:0] max_len;
        logic              free_avail;
        logic [BUF_W-1:0]  pop_idx;
        logic              grant_en;
        logic [BUF_W-1:0]  grant_idx;
    } t_chan_ctrl;

    // channel -> top
    typedef struct packed {
        logic              write_valid;
        logic [BYTE_W-1:0] write_offset;
        logic [BYTE_W-1:0] write_data;
        logic              frame_done;
        logic [BYTE_W-1:0] frame_length;
        logic [BUF_W-1:0]  buf_idx;
        t_err              error_code;
        logic              pop_req;
        logic              hold_req;
    } t_chan_stat;

endpackage

// ----- hdl/drfr_chan.sv -----
// Per-channel frame parser: phase, length, count, checksum and buffer ownership.
module drfr_chan
    import drfr_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_chan_ctrl i_ctrl,
    output t_chan_stat o_stat,
    output logic       o_wait_buf
);

    typedef enum logic [2:0] {
        PH_START  = 3'd0,
        PH_LEN_HI = 3'd1,
        PH_LEN_LO = 3'd2,
        PH_DATA   = 3'd3,
        PH_SUM    = 3'd4,
        PH_SKIP   = 3'd5
    } t_phase;

    t_phase            r_phase, n_phase, ph_eff;
    logic [BYTE_W-1:0] r_left,  n_left;
    logic [BYTE_W-1:0] r_count, n_count;
    logic [BYTE_W-1:0] r_sum,   n_sum;
    logic [BUF_W-1:0]  r_owned, n_owned;
    logic              r_owns,  n_owns;
    logic [BYTE_W-1:0] sum_add, left_dec;
    t_chan_stat        stat;

    assign sum_add  = r_sum + i_ctrl.rx_byte;
    assign left_dec = r_left - 8'd1;
    assign ph_eff   = i_ctrl.framing ? PH_START : r_phase;

    // mid-frame without a buffer: a returned buffer goes here first
    assign o_wait_buf = (r_phase != PH_START) && !r_owns;

    always_comb begin
        n_phase = r_phase;
        n_left  = r_left;
        n_count = r_count;
        n_sum   = r_sum;
        n_owned = r_owned;
        n_owns  = r_owns;
        stat    = '0;
        stat.error_code = ERR_NONE;

        if (i_ctrl.byte_en) begin
            if (i_ctrl.overrun) begin
                stat.error_code = ERR_OVERRUN;
                n_phase = PH_START;
            end else begin
                if (i_ctrl.framing) begin
                    stat.error_code = ERR_FRAMING;
                end
                unique case (ph_eff)
                    PH_LEN_HI: begin
                        if (i_ctrl.rx_byte == '0) begin
                            n_phase = PH_LEN_LO;
                        end else begin
                            stat.error_code = ERR_LEN_HIGH;
                            n_phase = PH_START;
                        end
                    end
                    PH_LEN_LO: begin
                        if (i_ctrl.rx_byte == '0 || i_ctrl.rx_byte > i_ctrl.max_len) begin
                            stat.error_code = ERR_LEN_RANGE;
                            n_phase = PH_START;
                        end else if (!r_owns) begin
                            stat.error_code = ERR_NO_BUFFER;
                            n_left  = i_ctrl.rx_byte;
                            n_phase = PH_SKIP;
                        end else begin
                            n_left  = i_ctrl.rx_byte;
                            n_count = '0;
                            n_sum   = '0;
                            n_phase = PH_DATA;
                        end
                    end
                    PH_DATA: begin
                        stat.write_valid  = 1'b1;
                        stat.buf_idx      = r_owned;
                        stat.write_offset = r_count;
                        stat.write_data   = i_ctrl.rx_byte;
                        n_count = r_count + 8'd1;
                        n_sum   = sum_add;
                        n_left  = left_dec;
                        if (left_dec == '0) begin
                            n_phase = PH_SUM;
                        end
                    end
                    PH_SUM: begin
                        n_sum = sum_add;
                        if (sum_add == SUM_TARGET) begin
                            stat.frame_done   = 1'b1;
                            stat.buf_idx      = r_owned;
                            stat.frame_length = r_count;
                            n_owns = 1'b0;
                        end else begin
                            stat.error_code = ERR_CHECKSUM;
                        end
                        n_phase = PH_START;
                    end
                    PH_SKIP: begin
                        if (r_left == '0) begin
                            n_phase = PH_START;
                        end else begin
                            n_left = left_dec;
                        end
                    end
                    default: begin
                        n_phase = PH_START;
                        if (i_ctrl.rx_byte == START_BYTE) begin
                            n_phase = PH_LEN_HI;
                            if (!r_owns) begin
                                if (i_ctrl.free_avail) begin
                                    stat.pop_req = 1'b1;
                                    n_owned = i_ctrl.pop_idx;
                                    n_owns  = 1'b1;
                                end else begin
                                    stat.hold_req = 1'b1;
                                end
                            end
                        end
                    end
                endcase
            end
        end

        if (i_ctrl.grant_en) begin
            n_owned = i_ctrl.grant_idx;
            n_owns  = 1'b1;
        end
    end

    assign o_stat = stat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_START;
            r_left  <= '0;
            r_count <= '0;
            r_sum   <= '0;
            r_owned <= '0;
            r_owns  <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_left  <= n_left;
            r_count <= n_count;
            r_sum   <= n_sum;
            r_owned <= n_owned;
            r_owns  <= n_owns;
        end
    end

`ifndef SYNTH
    a_payload_needs_buffer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_DATA || r_phase == PH_SUM) |-> r_owns)
        else $error("channel in payload or checksum without a buffer");

    a_done_frees_buffer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_stat.frame_done && !i_ctrl.grant_en) |=> !r_owns)
        else $error("buffer still owned after a finished frame");
`endif

endmodule

// ----- hdl/drfr_free_stack.sv -----
// LIFO of free buffer indexes shared by both channels.
module drfr_free_stack
    import drfr_pkg::*;
#(
    parameter int NUM_BUFFERS = NUM_BUFFERS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_pop,
    input  logic             i_push,
    input  logic [BUF_W-1:0] i_push_idx,
    output logic             o_avail,
    output logic [BUF_W-1:0] o_top
);

    localparam int CNT_W = $clog2(NUM_BUFFERS + 1);
    localparam int IDX_W = (NUM_BUFFERS > 1) ? $clog2(NUM_BUFFERS) : 1;

    logic [BUF_W-1:0] r_stack [NUM_BUFFERS];
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] top_pos;
    logic             full;

    assign top_pos = r_count - CNT_W'(1);
    assign full    = (r_count == CNT_W'(NUM_BUFFERS));
    assign o_avail = (r_count != '0);
    assign o_top   = r_stack[top_pos[IDX_W-1:0]];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_BUFFERS; i++) begin
                r_stack[i] <= BUF_W'(i);
            end
            r_count <= CNT_W'(NUM_BUFFERS);
        end else if (i_pop) begin
            r_count <= top_pos;
        end else if (i_push && !full) begin
            r_stack[r_count[IDX_W-1:0]] <= i_push_idx;
            r_count <= r_count + CNT_W'(1);
        end
    end

`ifndef SYNTH
    a_count_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(NUM_BUFFERS))
        else $error("free count above pool size");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> (o_avail && !i_push))
        else $error("pop from empty stack or pop with push");
`endif

endmodule

// ----- hdl/dual_channel_frame_receiver_core.sv -----
// Top level of the dual-channel frame receiver: request stage, channel parsers, result register.
//
// Two-channel receiver for framed UART bytes (0x7E, length high 0, length low
// 1..max_payload_length, payload, checksum making the byte sum 0xFF). Each
// accepted request produces exactly one result: the request is captured in an
// input register, the selected channel parser and the shared free-buffer stack
// update in a single pass, and the outcome is captured in the result register.
// One request per cycle is sustained while the output does not stall; the figure
// is set by the single-pass channel update and the one pop-or-push per cycle of
// the free stack. The result register decouples the two sides: while a result
// waits under stall, the input register still takes one more request and holds
// it until the result register drains, so at most two requests are in flight.
// The free stack and channel state are loaded directly by reset; there is no
// clearing pass. max_payload_length is written through i_cfg_wr_en/i_cfg_wr_data
// and must only change while idle.
module dual_channel_frame_receiver_core
    import drfr_pkg::*;
#(
    parameter int NUM_BUFFERS = NUM_BUFFERS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // request channel
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  t_rx_req           i_in_req,
    // result channel
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output t_rx_res           o_out_res,
    // configuration
    input  logic              i_cfg_wr_en,
    input  logic [BYTE_W-1:0] i_cfg_wr_data
);

    // request stage
    logic        r_req_valid;
    t_rx_req     r_req;
    logic        fire;

    // result stage
    logic        r_out_valid;
    t_rx_res     r_out;
    t_rx_res     n_out;

    logic [BYTE_W-1:0] r_max_len;
    logic [1:0]        r_hold, n_hold;

    t_chan_ctrl  ctrl [2];
    t_chan_stat  stat [2];
    t_chan_stat  sel;
    logic [1:0]  wait_buf;

    logic             stk_avail;
    logic [BUF_W-1:0] stk_top;
    logic             stk_pop, stk_push;
    logic             is_byte, is_return, ret_ok;
    logic             grant0, grant1;

    // A request advances when the result register is empty or being drained.
    assign fire       = r_req_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_req_valid && !fire;

    assign is_byte   = fire && (r_req.cmd == CMD_BYTE);
    assign is_return = fire && (r_req.cmd == CMD_RETURN);
    assign ret_ok    = (32'(r_req.returned_buffer) < NUM_BUFFERS);

    // Returned buffer goes first to channel 0 if it waits mid-frame, then channel 1.
    assign grant0   = is_return && ret_ok && wait_buf[0];
    assign grant1   = is_return && ret_ok && !wait_buf[0] && wait_buf[1];
    assign stk_push = is_return && ret_ok && !wait_buf[0] && !wait_buf[1];
    assign stk_pop  = stat[0].pop_req || stat[1].pop_req;

    always_comb begin
        for (int c = 0; c < 2; c++) begin
            ctrl[c].byte_en    = is_byte && (r_req.channel == 1'(c));
            ctrl[c].rx_byte    = r_req.rx_byte;
            ctrl[c].overrun    = r_req.overrun_flag;
            ctrl[c].framing    = r_req.framing_flag;
            ctrl[c].max_len    = r_max_len;
            ctrl[c].free_avail = stk_avail;
            ctrl[c].pop_idx    = stk_top;
            ctrl[c].grant_idx  = r_req.returned_buffer;
        end
        ctrl[0].grant_en = grant0;
        ctrl[1].grant_en = grant1;
    end

    drfr_chan u_chan0 (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctrl     (ctrl[0]),
        .o_stat     (stat[0]),
        .o_wait_buf (wait_buf[0])
    );

    drfr_chan u_chan1 (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctrl     (ctrl[1]),
        .o_stat     (stat[1]),
        .o_wait_buf (wait_buf[1])
    );

    drfr_free_stack #(
        .NUM_BUFFERS (NUM_BUFFERS)
    ) u_free_stack (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_pop      (stk_pop),
        .i_push     (stk_push),
        .i_push_idx (r_req.returned_buffer),
        .o_avail    (stk_avail),
        .o_top      (stk_top)
    );

    // RTS hold-off lines, bit 0 for channel 0.
    always_comb begin
        n_hold = r_hold;
        if (fire) begin
            unique case (r_req.cmd)
                CMD_BYTE: begin
                    n_hold = r_hold | {stat[1].hold_req, stat[0].hold_req};
                end
                CMD_RETURN: begin
                    if (grant0) begin
                        n_hold = r_hold & 2'b10;
                    end else if (grant1) begin
                        n_hold = r_hold & 2'b01;
                    end else if (ret_ok) begin
                        n_hold = 2'b00;
                    end
                end
                CMD_RESUME: begin
                    if (stk_avail) begin
                        n_hold = 2'b00;
                    end
                end
                CMD_SUSPEND: begin
                    n_hold = 2'b11;
                end
            endcase
        end
    end

    assign sel = r_req.channel ? stat[1] : stat[0];

    always_comb begin
        n_out = '0;
        n_out.error_code = ERR_NONE;
        if (r_req.cmd == CMD_BYTE) begin
            n_out.write_valid   = sel.write_valid;
            n_out.write_buffer  = sel.buf_idx;
            n_out.write_offset  = sel.write_offset;
            n_out.write_data    = sel.write_data;
            n_out.frame_done    = sel.frame_done;
            n_out.frame_length  = sel.frame_length;
            n_out.event_channel = r_req.channel;
            n_out.error_code    = sel.error_code;
        end
        n_out.rts_hold_0 = n_hold[0];
        n_out.rts_hold_1 = n_hold[1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_valid <= 1'b0;
            r_out_valid <= 1'b0;
            r_hold      <= 2'b11;
            r_max_len   <= MAX_LEN_RESET;
        end else begin
            if (!o_in_stall) begin
                r_req_valid <= i_in_valid;
            end
            if (fire) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            r_hold <= n_hold;
            if (i_cfg_wr_en) begin
                r_max_len <= i_cfg_wr_data;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_req <= i_in_req;
        end
        if (fire) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_res   = r_out;

`ifndef SYNTH
    a_single_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(stat[0].pop_req && stat[1].pop_req))
        else $error("both channels popped a buffer in one cycle");

    a_stalled_request_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_req_valid && !fire) |=> r_req_valid)
        else $error("request dropped from input register");
`endif

endmodule
